// File: hdl/tt_pkg.sv
// Shared widths, register indexes and pipeline control type for the tile coverage block.
`default_nettype none

package tt_pkg;

	localparam int VTX_W     = 18;
	localparam int TILE_W    = 9;
	localparam int CFG_W     = 13;
	localparam int MASK_W    = 64;
	localparam int DIFF_W    = VTX_W + 1;
	localparam int PC_W      = DIFF_W + VTX_W;
	localparam int CMP_W     = 20;
	localparam int NUM_EDGES = 3;
	localparam int NUM_STAGES = 7;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;

	// Load enables, one per pipeline stage.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} tt_adv_t;

endpackage

`default_nettype wire

// File: hdl/tt_tri_if.sv
// Triangle and tile request channel.
`default_nettype none

interface tt_tri_if;
	import tt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [VTX_W-1:0]  vertex_a_x;
	logic signed [VTX_W-1:0]  vertex_a_y;
	logic signed [VTX_W-1:0]  vertex_b_x;
	logic signed [VTX_W-1:0]  vertex_b_y;
	logic signed [VTX_W-1:0]  vertex_c_x;
	logic signed [VTX_W-1:0]  vertex_c_y;
	logic [TILE_W-1:0]        tile_col;
	logic [TILE_W-1:0]        tile_row;

	modport source (
		output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		output vertex_c_x, vertex_c_y, tile_col, tile_row,
		input  ready
	);
	modport sink (
		input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
		input  vertex_c_x, vertex_c_y, tile_col, tile_row,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/tt_mask_if.sv
// Coverage mask result channel.
`default_nettype none

interface tt_mask_if;
	import tt_pkg::*;

	logic               valid;
	logic               ready;
	logic [MASK_W-1:0]  coverage_mask;
	logic [TILE_W-1:0]  out_tile_col;
	logic [TILE_W-1:0]  out_tile_row;

	modport source (
		output valid, coverage_mask, out_tile_col, out_tile_row,
		input  ready
	);
	modport sink (
		input  valid, coverage_mask, out_tile_col, out_tile_row,
		output ready
	);
endinterface

`default_nettype wire

// File: hdl/tt_cfg_if.sv
// Configuration register write channel.
`default_nettype none

interface tt_cfg_if;
	import tt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/tt_setup.sv
// Triangle setup: edge deltas, bounds, edge constants and edge values at the tile origin.
`default_nettype none

module tt_setup
	import tt_pkg::*;
#(
	parameter int TILE_SIZE     = 8,
	parameter int SUBPIXEL_BITS = 4,
	parameter int PX_W          = 12,
	parameter int FY_W          = 17,
	parameter int EW            = 40,
	parameter int BW            = 15
) (
	input  logic                     clk,
	input  tt_adv_t                  adv,
	input  logic signed [VTX_W-1:0]  vertex_a_x,
	input  logic signed [VTX_W-1:0]  vertex_a_y,
	input  logic signed [VTX_W-1:0]  vertex_b_x,
	input  logic signed [VTX_W-1:0]  vertex_b_y,
	input  logic signed [VTX_W-1:0]  vertex_c_x,
	input  logic signed [VTX_W-1:0]  vertex_c_y,
	input  logic [TILE_W-1:0]        tile_col,
	input  logic [TILE_W-1:0]        tile_row,
	input  logic [CFG_W-1:0]         screen_width,
	input  logic [CFG_W-1:0]         screen_height,
	output logic signed [EW-1:0]     e0_s4 [NUM_EDGES],
	output logic signed [DIFF_W-1:0] dx_s4 [NUM_EDGES],
	output logic signed [DIFF_W-1:0] dy_s4 [NUM_EDGES],
	output logic [TILE_SIZE-1:0]     col_ok_s4,
	output logic [TILE_SIZE-1:0]     row_ok_s4
);

	localparam int RND  = (1 << SUBPIXEL_BITS) - 1;
	localparam int FP_W = DIFF_W + FY_W;

	function automatic logic signed [BW-1:0] rnd_bound(input logic signed [VTX_W-1:0] v);
		logic signed [DIFF_W-1:0] t;
		t = (DIFF_W'(v) + DIFF_W'(RND)) >>> SUBPIXEL_BITS;
		return t[BW-1:0];
	endfunction

	logic signed [VTX_W-1:0]  vx [NUM_EDGES];
	logic signed [VTX_W-1:0]  vy [NUM_EDGES];
	logic signed [VTX_W-1:0]  min_x, max_x, min_y, max_y;

	logic signed [DIFF_W-1:0] dx_s1 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dy_s1 [NUM_EDGES];
	logic signed [VTX_W-1:0]  x0_s1 [NUM_EDGES];
	logic signed [VTX_W-1:0]  y0_s1 [NUM_EDGES];
	logic [NUM_EDGES-1:0]     tl_s1;
	logic signed [BW-1:0]     minx_s1, maxx_s1, miny_s1, maxy_s1;
	logic [PX_W-1:0]          px0_s1, py0_s1;

	logic signed [PC_W-1:0]   cx_s2 [NUM_EDGES];
	logic signed [PC_W-1:0]   cy_s2 [NUM_EDGES];
	logic signed [FP_W-1:0]   fyp_s2 [NUM_EDGES];
	logic signed [FP_W-1:0]   fxp_s2 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dx_s2 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dy_s2 [NUM_EDGES];
	logic [NUM_EDGES-1:0]     tl_s2;
	logic [TILE_SIZE-1:0]     col_ok_s2, row_ok_s2;
	logic [TILE_SIZE-1:0]     col_ok_d, row_ok_d;
	logic signed [FY_W-1:0]   fx0, fy0;

	logic signed [EW-1:0]     c_s3 [NUM_EDGES];
	logic signed [EW-1:0]     f_s3 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dx_s3 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dy_s3 [NUM_EDGES];
	logic [TILE_SIZE-1:0]     col_ok_s3, row_ok_s3;

	assign vx[0] = vertex_a_x;
	assign vy[0] = vertex_a_y;
	assign vx[1] = vertex_b_x;
	assign vy[1] = vertex_b_y;
	assign vx[2] = vertex_c_x;
	assign vy[2] = vertex_c_y;

	always_comb begin
		min_x = vx[0];
		max_x = vx[0];
		min_y = vy[0];
		max_y = vy[0];
		for (int i = 1; i < NUM_EDGES; i++) begin
			if (vx[i] < min_x) min_x = vx[i];
			if (vx[i] > max_x) max_x = vx[i];
			if (vy[i] < min_y) min_y = vy[i];
			if (vy[i] > max_y) max_y = vy[i];
		end
	end

	// Stage 1: edge deltas, fill rule and rounded bounds.
	for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge_s1
		localparam int NXT = (e + 1) % NUM_EDGES;
		logic signed [DIFF_W-1:0] dx_d, dy_d;

		assign dx_d = DIFF_W'(vx[e]) - DIFF_W'(vx[NXT]);
		assign dy_d = DIFF_W'(vy[e]) - DIFF_W'(vy[NXT]);

		always_ff @(posedge clk) begin
			if (adv.s1) begin
				dx_s1[e] <= dx_d;
				dy_s1[e] <= dy_d;
				x0_s1[e] <= vx[e];
				y0_s1[e] <= vy[e];
				tl_s1[e] <= (dy_d < 0) || ((dy_d == 0) && (dx_d > 0));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			minx_s1 <= rnd_bound(min_x);
			maxx_s1 <= rnd_bound(max_x);
			miny_s1 <= rnd_bound(min_y);
			maxy_s1 <= rnd_bound(max_y);
			px0_s1  <= PX_W'(tile_col) * PX_W'(TILE_SIZE);
			py0_s1  <= PX_W'(tile_row) * PX_W'(TILE_SIZE);
		end
	end

	// Stage 2: products for the edge constants and the tile origin offsets.
	assign fx0 = $signed({1'b0, px0_s1, {SUBPIXEL_BITS{1'b0}}});
	assign fy0 = $signed({1'b0, py0_s1, {SUBPIXEL_BITS{1'b0}}});

	for (genvar k = 0; k < TILE_SIZE; k++) begin : g_bounds
		logic [PX_W-1:0]         px, py;
		logic signed [CMP_W-1:0] sx, sy;

		assign px = px0_s1 + PX_W'(k);
		assign py = py0_s1 + PX_W'(k);
		assign sx = CMP_W'($signed({1'b0, px}));
		assign sy = CMP_W'($signed({1'b0, py}));
		assign col_ok_d[k] = (sx >= CMP_W'(minx_s1)) && (sx < CMP_W'(maxx_s1))
			&& (CFG_W'(px) < screen_width);
		assign row_ok_d[k] = (sy >= CMP_W'(miny_s1)) && (sy < CMP_W'(maxy_s1))
			&& (CFG_W'(py) < screen_height);
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				cx_s2[e]  <= PC_W'(dy_s1[e]) * PC_W'(x0_s1[e]);
				cy_s2[e]  <= PC_W'(dx_s1[e]) * PC_W'(y0_s1[e]);
				fyp_s2[e] <= FP_W'(dx_s1[e]) * FP_W'(fy0);
				fxp_s2[e] <= FP_W'(dy_s1[e]) * FP_W'(fx0);
				dx_s2[e]  <= dx_s1[e];
				dy_s2[e]  <= dy_s1[e];
			end
			tl_s2     <= tl_s1;
			col_ok_s2 <= col_ok_d;
			row_ok_s2 <= row_ok_d;
		end
	end

	// Stage 3: edge constant with fill adjustment, and the tile origin offset.
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				c_s3[e]  <= EW'(cx_s2[e]) - EW'(cy_s2[e]) + (tl_s2[e] ? EW'(1) : EW'(0));
				f_s3[e]  <= EW'(fyp_s2[e]) - EW'(fxp_s2[e]);
				dx_s3[e] <= dx_s2[e];
				dy_s3[e] <= dy_s2[e];
			end
			col_ok_s3 <= col_ok_s2;
			row_ok_s3 <= row_ok_s2;
		end
	end

	// Stage 4: edge values at the tile's top-left pixel.
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				e0_s4[e] <= c_s3[e] + f_s3[e];
				dx_s4[e] <= dx_s3[e];
				dy_s4[e] <= dy_s3[e];
			end
			col_ok_s4 <= col_ok_s3;
			row_ok_s4 <= row_ok_s3;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tt_lane.sv
// One tile row: steps the edge values down to its row and tests every pixel in it.
`default_nettype none

module tt_lane
	import tt_pkg::*;
#(
	parameter int ROW           = 0,
	parameter int TILE_SIZE     = 8,
	parameter int SUBPIXEL_BITS = 4,
	parameter int EW            = 40
) (
	input  logic                     clk,
	input  tt_adv_t                  adv,
	input  logic signed [EW-1:0]     e0 [NUM_EDGES],
	input  logic signed [DIFF_W-1:0] dx [NUM_EDGES],
	input  logic signed [DIFF_W-1:0] dy [NUM_EDGES],
	input  logic                     row_ok,
	input  logic [TILE_SIZE-1:0]     col_ok,
	output logic [TILE_SIZE-1:0]     hits_s6
);

	localparam int ROW_STEP = ROW << SUBPIXEL_BITS;
	localparam int COL_STEP = 1 << SUBPIXEL_BITS;

	logic signed [EW-1:0]     erow_s5 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dy_s5 [NUM_EDGES];
	logic [TILE_SIZE-1:0]     ok_s5;
	logic [TILE_SIZE-1:0]     hits_d;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			for (int e = 0; e < NUM_EDGES; e++) begin
				erow_s5[e] <= e0[e] + EW'(dx[e]) * EW'(ROW_STEP);
				dy_s5[e]   <= dy[e];
			end
			ok_s5 <= row_ok ? col_ok : '0;
		end
	end

	for (genvar c = 0; c < TILE_SIZE; c++) begin : g_col
		localparam int X_STEP = c * COL_STEP;
		logic [NUM_EDGES-1:0] above;

		for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
			logic signed [EW-1:0] ev;

			assign ev = erow_s5[e] - EW'(dy_s5[e]) * EW'(X_STEP);
			assign above[e] = (ev > 0);
		end

		assign hits_d[c] = ok_s5[c] && (&above);
	end

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			hits_s6 <= hits_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/tt_merge.sv
// Gathers the row lanes into one mask and carries the tile position alongside it.
`default_nettype none

module tt_merge
	import tt_pkg::*;
#(
	parameter int TILE_SIZE = 8
) (
	input  logic                            clk,
	input  tt_adv_t                         adv,
	input  logic [TILE_W-1:0]               tile_col,
	input  logic [TILE_W-1:0]               tile_row,
	input  logic [TILE_SIZE*TILE_SIZE-1:0]  hits_s6,
	output logic [MASK_W-1:0]               mask_s7,
	output logic [TILE_W-1:0]               col_s7,
	output logic [TILE_W-1:0]               row_s7
);

	logic [TILE_W-1:0] col_pipe [NUM_STAGES-1];
	logic [TILE_W-1:0] row_pipe [NUM_STAGES-1];
	logic [NUM_STAGES-2:0] pipe_en;

	assign pipe_en = {adv.s6, adv.s5, adv.s4, adv.s3, adv.s2, adv.s1};

	always_ff @(posedge clk) begin
		if (pipe_en[0]) begin
			col_pipe[0] <= tile_col;
			row_pipe[0] <= tile_row;
		end
		for (int k = 1; k < NUM_STAGES - 1; k++) begin
			if (pipe_en[k]) begin
				col_pipe[k] <= col_pipe[k-1];
				row_pipe[k] <= row_pipe[k-1];
			end
		end
	end

	// Rows arrive packed row-major, so the lane bits land in place.
	always_ff @(posedge clk) begin
		if (adv.s7) begin
			mask_s7 <= MASK_W'(hits_s6);
			col_s7  <= col_pipe[NUM_STAGES-2];
			row_s7  <= row_pipe[NUM_STAGES-2];
		end
	end

endmodule

`default_nettype wire

// File: hdl/triangle_tile_coverage.sv
// Top level of the half-space triangle tile coverage block.
//
// Each beat on tri_item carries one triangle (three vertices in signed fixed
// point with SUBPIXEL_BITS fraction bits) and one TILE_SIZE x TILE_SIZE tile.
// For that beat exactly one beat leaves on tile_mask: a coverage mask with bit
// row*TILE_SIZE+col set for every covered pixel, plus the tile position.
// The cfg channel writes the screen width (index 0) and height (index 1); it
// is always ready and should only be used while no request is in flight.
//
// From acceptance to the result beat the work passes four setup stages
// (deltas and bounds, products, edge constants, tile origin values), two
// stages in the row lanes and the output register. One lane per tile row
// tests all its pixels in parallel, so a new beat is accepted every cycle
// while the receiver keeps up. Throughput is one tile per cycle, set by the fully pipelined lanes.
//
// Each stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so when the receiver stalls the bubbles close up and
// input beats are still accepted until every stage holds work.
// Reset empties the pipeline and restores the screen size to 640 x 480.
`default_nettype none

module triangle_tile_coverage
	import tt_pkg::*;
#(
	parameter int TILE_SIZE     = 8,
	parameter int SUBPIXEL_BITS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	tt_tri_if.sink    tri_item,
	tt_mask_if.source tile_mask,
	tt_cfg_if.sink    cfg
);

	// Pixel coordinates reach TILE_SIZE times the tile range minus one.
	localparam int PX_W = $clog2((1 << TILE_W) * TILE_SIZE);
	// Signed pixel coordinate scaled to subpixel units.
	localparam int FY_W = PX_W + SUBPIXEL_BITS + 1;
	localparam int FP_W = DIFF_W + FY_W;
	// Edge value width: the widest product plus headroom for the sums.
	localparam int EW   = ((FP_W > PC_W + 1) ? FP_W : (PC_W + 1)) + 2;
	// Rounded bounds need the delta width less the fraction bits.
	localparam int BW   = DIFF_W - SUBPIXEL_BITS;

	logic [CFG_W-1:0] screen_width_q;
	logic [CFG_W-1:0] screen_height_q;

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] rdy;
	tt_adv_t             adv;

	logic signed [EW-1:0]     e0_s4 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dx_s4 [NUM_EDGES];
	logic signed [DIFF_W-1:0] dy_s4 [NUM_EDGES];
	logic [TILE_SIZE-1:0]     col_ok_s4;
	logic [TILE_SIZE-1:0]     row_ok_s4;

	logic [TILE_SIZE*TILE_SIZE-1:0] hits_s6;

	// Configuration registers. Writes are taken on every beat.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RESET;
			screen_height_q <= SCREEN_HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SCREEN_WIDTH: begin
					screen_width_q <= cfg.data;
				end
				REG_SCREEN_HEIGHT: begin
					screen_height_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// A stage may load when it is empty or its successor is moving on.
	always_comb begin
		rdy[NUM_STAGES] = !vld_q[NUM_STAGES] || tile_mask.ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign adv = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4],
		s5: rdy[5], s6: rdy[6], s7: rdy[7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) vld_q[1] <= tri_item.valid;
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign tri_item.ready  = rdy[1];
	assign tile_mask.valid = vld_q[NUM_STAGES];

	tt_setup #(
		.TILE_SIZE     (TILE_SIZE),
		.SUBPIXEL_BITS (SUBPIXEL_BITS),
		.PX_W          (PX_W),
		.FY_W          (FY_W),
		.EW            (EW),
		.BW            (BW)
	) u_setup (
		.clk           (clk),
		.adv           (adv),
		.vertex_a_x    (tri_item.vertex_a_x),
		.vertex_a_y    (tri_item.vertex_a_y),
		.vertex_b_x    (tri_item.vertex_b_x),
		.vertex_b_y    (tri_item.vertex_b_y),
		.vertex_c_x    (tri_item.vertex_c_x),
		.vertex_c_y    (tri_item.vertex_c_y),
		.tile_col      (tri_item.tile_col),
		.tile_row      (tri_item.tile_row),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.e0_s4         (e0_s4),
		.dx_s4         (dx_s4),
		.dy_s4         (dy_s4),
		.col_ok_s4     (col_ok_s4),
		.row_ok_s4     (row_ok_s4)
	);

	// One lane per tile row; each tests its whole row in the same cycle.
	for (genvar r = 0; r < TILE_SIZE; r++) begin : g_lane
		tt_lane #(
			.ROW           (r),
			.TILE_SIZE     (TILE_SIZE),
			.SUBPIXEL_BITS (SUBPIXEL_BITS),
			.EW            (EW)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.e0      (e0_s4),
			.dx      (dx_s4),
			.dy      (dy_s4),
			.row_ok  (row_ok_s4[r]),
			.col_ok  (col_ok_s4),
			.hits_s6 (hits_s6[r*TILE_SIZE +: TILE_SIZE])
		);
	end

	tt_merge #(
		.TILE_SIZE (TILE_SIZE)
	) u_merge (
		.clk      (clk),
		.adv      (adv),
		.tile_col (tri_item.tile_col),
		.tile_row (tri_item.tile_row),
		.hits_s6  (hits_s6),
		.mask_s7  (tile_mask.coverage_mask),
		.col_s7   (tile_mask.out_tile_col),
		.row_s7   (tile_mask.out_tile_row)
	);

endmodule

`default_nettype wire

// File: hdl/tt_checker.sv
// Port-level checks for the tile coverage block, bound to its top level.
`default_nettype none

module tt_checker
	import tt_pkg::*;
#(
	parameter int TILE_SIZE = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [MASK_W-1:0]     out_mask,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(NUM_STAGES + 2);

	logic [CNT_W-1:0] inflight_q;
	logic             zero_width_q;
	logic             in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q   <= '0;
			zero_width_q <= 1'b0;
		end else begin
			if (in_acc && !out_acc) inflight_q <= inflight_q + CNT_W'(1);
			else if (!in_acc && out_acc) inflight_q <= inflight_q - CNT_W'(1);
			if (cfg_valid && cfg_ready && (cfg_index == REG_SCREEN_WIDTH)) begin
				zero_width_q <= (cfg_data == '0);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mask))
		else $error("result beat changed while stalled");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(NUM_STAGES))
		else $error("more requests in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result beat without an accepted request");

	a_mask_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_mask >> (TILE_SIZE * TILE_SIZE)) == '0)
		else $error("mask bits set beyond the tile");

	a_zero_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_width_q |-> out_mask == '0)
		else $error("pixels covered on a zero-width screen");

endmodule

bind triangle_tile_coverage tt_checker #(
	.TILE_SIZE (TILE_SIZE)
) u_tt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (tri_item.valid),
	.in_ready  (tri_item.ready),
	.out_valid (tile_mask.valid),
	.out_ready (tile_mask.ready),
	.out_mask  (tile_mask.coverage_mask),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.cfg_index (cfg.index),
	.cfg_data  (cfg.data)
);

`default_nettype wire

// File: tb/sv/tt_tb_pkg.sv
// Beat types, constants and the coverage scoreboard for the tile coverage testbench.
package tt_tb_pkg;
	import tt_pkg::*;

	localparam int TILE_PX  = 8;
	localparam int SUB_BITS = 4;
	localparam int SUB_ONE  = 1 << SUB_BITS;

	typedef struct packed {
		logic signed [VTX_W-1:0] ax;
		logic signed [VTX_W-1:0] ay;
		logic signed [VTX_W-1:0] bx;
		logic signed [VTX_W-1:0] by;
		logic signed [VTX_W-1:0] cx;
		logic signed [VTX_W-1:0] cy;
		logic [TILE_W-1:0]       col;
		logic [TILE_W-1:0]       row;
	} tri_req_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		logic [TILE_W-1:0] col;
		logic [TILE_W-1:0] row;
	} mask_beat_t;

	class tile_mask_board;
		logic [CFG_W-1:0] scr_w;
		logic [CFG_W-1:0] scr_h;
		mask_beat_t       pending_masks[$];
		int               errors;

		function new();
			scr_w  = SCREEN_WIDTH_RESET;
			scr_h  = SCREEN_HEIGHT_RESET;
			errors = 0;
		endfunction

		// Pixel bound from a subpixel coordinate, rounded up with a floor shift.
		function longint px_bound(input longint v);
			return (v + SUB_ONE - 1) >>> SUB_BITS;
		endfunction

		// Edge constant, biased by one on top and left edges.
		function longint edge_origin(input longint x0, input longint y0,
				input longint dx, input longint dy);
			longint c;
			c = dy * x0 - dx * y0;
			if (dy < 0 || (dy == 0 && dx > 0)) c = c + 1;
			return c;
		endfunction

		// Works out the mask for one accepted triangle and tile and queues it.
		function void queue_coverage(input tri_req_t t);
			longint x1, y1, x2, y2, x3, y3;
			longint dx12, dx23, dx31, dy12, dy23, dy31;
			longint minx, maxx, miny, maxy, c1, c2, c3;
			longint px, py, e1, e2, e3;
			mask_beat_t m;
			x1 = $signed(t.ax);
			y1 = $signed(t.ay);
			x2 = $signed(t.bx);
			y2 = $signed(t.by);
			x3 = $signed(t.cx);
			y3 = $signed(t.cy);
			dx12 = x1 - x2;
			dx23 = x2 - x3;
			dx31 = x3 - x1;
			dy12 = y1 - y2;
			dy23 = y2 - y3;
			dy31 = y3 - y1;
			minx = px_bound((x1 < x2) ? ((x1 < x3) ? x1 : x3) : ((x2 < x3) ? x2 : x3));
			maxx = px_bound((x1 > x2) ? ((x1 > x3) ? x1 : x3) : ((x2 > x3) ? x2 : x3));
			miny = px_bound((y1 < y2) ? ((y1 < y3) ? y1 : y3) : ((y2 < y3) ? y2 : y3));
			maxy = px_bound((y1 > y2) ? ((y1 > y3) ? y1 : y3) : ((y2 > y3) ? y2 : y3));
			c1 = edge_origin(x1, y1, dx12, dy12);
			c2 = edge_origin(x2, y2, dx23, dy23);
			c3 = edge_origin(x3, y3, dx31, dy31);
			m.mask = '0;
			m.col  = t.col;
			m.row  = t.row;
			for (int r = 0; r < TILE_PX; r++) begin
				py = longint'(t.row) * TILE_PX + r;
				for (int c = 0; c < TILE_PX; c++) begin
					px = longint'(t.col) * TILE_PX + c;
					if (py >= miny && py < maxy && py < longint'(scr_h) &&
							px >= minx && px < maxx && px < longint'(scr_w)) begin
						e1 = c1 + dx12 * (py * SUB_ONE) - dy12 * (px * SUB_ONE);
						e2 = c2 + dx23 * (py * SUB_ONE) - dy23 * (px * SUB_ONE);
						e3 = c3 + dx31 * (py * SUB_ONE) - dy31 * (px * SUB_ONE);
						if (e1 > 0 && e2 > 0 && e3 > 0) m.mask[r * TILE_PX + c] = 1'b1;
					end
				end
			end
			pending_masks.push_back(m);
		endfunction

		function void check_coverage(input mask_beat_t got);
			mask_beat_t want;
			if (pending_masks.size() == 0) begin
				errors++;
				$display("%0t: unexpected mask beat, expected none, actual mask %h tile (%0d,%0d)",
					$time, got.mask, got.col, got.row);
				return;
			end
			want = pending_masks.pop_front();
			if (got.mask !== want.mask) begin
				errors++;
				$display("%0t: coverage_mask expected %h actual %h", $time, want.mask, got.mask);
			end
			if (got.col !== want.col) begin
				errors++;
				$display("%0t: out_tile_col expected %0d actual %0d", $time, want.col, got.col);
			end
			if (got.row !== want.row) begin
				errors++;
				$display("%0t: out_tile_row expected %0d actual %0d", $time, want.row, got.row);
			end
		endfunction
	endclass

endpackage

// File: tb/sv/testbench.sv
// Self-checking testbench for the triangle tile coverage block.
module testbench;
	import tt_pkg::*;
	import tt_tb_pkg::*;

	// Cycles from an accepted request beat to its mask beat through an unstalled pipeline.
	localparam int LATENCY = 7;
	localparam int NUM_PHASES = 9;

	logic clk = 1'b0;
	logic arst_n;

	always #4 clk = ~clk;

	tt_tri_if  tri_bus();
	tt_mask_if mask_bus();
	tt_cfg_if  cfg_bus();

	triangle_tile_coverage #(
		.TILE_SIZE     (TILE_PX),
		.SUBPIXEL_BITS (SUB_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.tri_item  (tri_bus),
		.tile_mask (mask_bus),
		.cfg       (cfg_bus)
	);

	tile_mask_board sb;

	// Idling switches for either side, and the request for one long receiver stall.
	bit tx_idle_on;
	bit rx_idle_on;
	bit long_hold_req;

	// Every beat is observed at the rising edge, where the values driven at the
	// previous falling edge are settled. A request beat is predicted at once; a
	// mask beat is checked against the oldest prediction still waiting.
	always @(posedge clk) begin
		if (arst_n && tri_bus.valid && tri_bus.ready)
			sb.queue_coverage(tri_req_t'{tri_bus.vertex_a_x, tri_bus.vertex_a_y,
				tri_bus.vertex_b_x, tri_bus.vertex_b_y, tri_bus.vertex_c_x,
				tri_bus.vertex_c_y, tri_bus.tile_col, tri_bus.tile_row});
		if (arst_n && mask_bus.valid && mask_bus.ready)
			sb.check_coverage(mask_beat_t'{mask_bus.coverage_mask,
				mask_bus.out_tile_col, mask_bus.out_tile_row});
	end

	// The receiver. It stalls at random while idling is
	// enabled, and once in the run holds off for a long stretch so that the whole
	// pipeline fills and the block has to refuse request beats. The stretch is
	// counted down here, in cycles, whatever the sender is doing meanwhile.
	initial begin
		int stall_left;
		stall_left = 0;
		mask_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = 90;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				mask_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				mask_bus.ready <= 1'b1;
			end
		end
	end

	// The run is cut short if it hangs; a correct run takes a small part of this.
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic drive_fields(input tri_req_t t);
		tri_bus.vertex_a_x <= t.ax;
		tri_bus.vertex_a_y <= t.ay;
		tri_bus.vertex_b_x <= t.bx;
		tri_bus.vertex_b_y <= t.by;
		tri_bus.vertex_c_x <= t.cx;
		tri_bus.vertex_c_y <= t.cy;
		tri_bus.tile_col   <= t.col;
		tri_bus.tile_row   <= t.row;
	endtask

	// Offers one request beat and returns at the falling edge after it is taken.
	// Valid stays high, so back-to-back beats need no gap.
	task automatic put_tri(input tri_req_t t);
		tri_bus.valid <= 1'b1;
		drive_fields(t);
		do @(posedge clk); while (!(tri_bus.valid && tri_bus.ready));
		@(negedge clk);
	endtask

	task automatic put_vtx(input int ax, input int ay, input int bx, input int by,
			input int cx, input int cy, input int col, input int row);
		tri_req_t t;
		t.ax  = VTX_W'(ax);
		t.ay  = VTX_W'(ay);
		t.bx  = VTX_W'(bx);
		t.by  = VTX_W'(by);
		t.cx  = VTX_W'(cx);
		t.cy  = VTX_W'(cy);
		t.col = TILE_W'(col);
		t.row = TILE_W'(row);
		put_tri(t);
	endtask

	// A random sender gap, with junk on the payload while valid is low.
	task automatic tx_gap();
		tri_req_t junk;
		logic [127:0] noise;
		noise = {$urandom, $urandom, $urandom, $urandom};
		junk = noise[$bits(tri_req_t)-1:0];
		tri_bus.valid <= 1'b0;
		drive_fields(junk);
		repeat ($urandom_range(1, 7)) @(negedge clk);
	endtask

	// Stops offering and waits until every predicted mask has arrived, then lets
	// the pipeline run dry so that a register write cannot overtake any work.
	task automatic settle();
		tri_bus.valid <= 1'b0;
		while (sb.pending_masks.size() != 0) @(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// One register write beat. Valid is left high for a following write; the
	// caller lowers it once the last one is through.
	task automatic wr_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
		if (idx == REG_SCREEN_WIDTH) sb.scr_w = val;
		else sb.scr_h = val;
		@(negedge clk);
	endtask

	function automatic int near_sub(input bit snap);
		int v;
		v = int'($urandom_range(0, 640)) - 256;
		return snap ? (v & ~15) : v;
	endfunction

	// A random request beat. Most tiles lie on the configured screen, some sit on
	// its right or bottom border and the rest anywhere. Half the triangles are placed
	// around the chosen tile so that masks come out partly covered; the others
	// are large covering triangles, fully random vertices, degenerate ones and
	// axis-aligned right triangles on whole pixels that land exactly on samples.
	function automatic tri_req_t rand_tri();
		tri_req_t t;
		int maxc, maxr, sel, ox, oy, ddx, ddy, k, j, wd, ht;
		bit snap;
		maxc = (sb.scr_w == 0) ? 511 : (int'(sb.scr_w) - 1) / TILE_PX;
		maxr = (sb.scr_h == 0) ? 511 : (int'(sb.scr_h) - 1) / TILE_PX;
		if (maxc > 511) maxc = 511;
		if (maxr > 511) maxr = 511;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			t.col = TILE_W'($urandom_range(0, maxc));
			t.row = TILE_W'($urandom_range(0, maxr));
		end else if (sel < 70) begin
			t.col = $urandom_range(0, 1) ? TILE_W'(maxc) : TILE_W'($urandom_range(0, maxc));
			t.row = (t.col == maxc && $urandom_range(0, 1)) ?
				TILE_W'($urandom_range(0, maxr)) : TILE_W'(maxr);
		end else begin
			t.col = TILE_W'($urandom_range(0, 511));
			t.row = TILE_W'($urandom_range(0, 511));
		end
		ox = int'(t.col) * TILE_PX * SUB_ONE;
		oy = int'(t.row) * TILE_PX * SUB_ONE;
		snap = ($urandom_range(0, 2) == 0);
		sel = $urandom_range(0, 99);
		if (sel < 50) begin
			t.ax = VTX_W'(ox + near_sub(snap));
			t.ay = VTX_W'(oy + near_sub(snap));
			t.bx = VTX_W'(ox + near_sub(snap));
			t.by = VTX_W'(oy + near_sub(snap));
			t.cx = VTX_W'(ox + near_sub(snap));
			t.cy = VTX_W'(oy + near_sub(snap));
		end else if (sel < 65) begin
			t.ax = VTX_W'(ox + int'($urandom_range(0, 40000)) - 20000);
			t.ay = VTX_W'(oy + int'($urandom_range(0, 40000)) - 20000);
			t.bx = VTX_W'(ox + int'($urandom_range(0, 40000)) - 20000);
			t.by = VTX_W'(oy + int'($urandom_range(0, 40000)) - 20000);
			t.cx = VTX_W'(ox + int'($urandom_range(0, 40000)) - 20000);
			t.cy = VTX_W'(oy + int'($urandom_range(0, 40000)) - 20000);
		end else if (sel < 75) begin
			t.ax = VTX_W'($urandom);
			t.ay = VTX_W'($urandom);
			t.bx = VTX_W'($urandom);
			t.by = VTX_W'($urandom);
			t.cx = VTX_W'($urandom);
			t.cy = VTX_W'($urandom);
		end else if (sel < 85) begin
			// Collinear or coincident vertices.
			ddx = int'($urandom_range(0, 128)) - 64;
			ddy = int'($urandom_range(0, 128)) - 64;
			k = int'($urandom_range(0, 8)) - 4;
			j = int'($urandom_range(0, 8)) - 4;
			t.ax = VTX_W'(ox + near_sub(snap));
			t.ay = VTX_W'(oy + near_sub(snap));
			t.bx = VTX_W'(t.ax + k * ddx);
			t.by = VTX_W'(t.ay + k * ddy);
			t.cx = VTX_W'(t.ax + j * ddx);
			t.cy = VTX_W'(t.ay + j * ddy);
		end else begin
			wd = SUB_ONE * int'($urandom_range(1, 12)) * ($urandom_range(0, 1) ? 1 : -1);
			ht = SUB_ONE * int'($urandom_range(1, 12)) * ($urandom_range(0, 1) ? 1 : -1);
			t.ax = VTX_W'(ox + SUB_ONE * (int'($urandom_range(0, 16)) - 4));
			t.ay = VTX_W'(oy + SUB_ONE * (int'($urandom_range(0, 16)) - 4));
			if ($urandom_range(0, 1)) begin
				t.bx = VTX_W'(t.ax + wd);
				t.by = t.ay;
				t.cx = t.ax;
				t.cy = VTX_W'(t.ay + ht);
			end else begin
				t.bx = t.ax;
				t.by = VTX_W'(t.ay + ht);
				t.cx = VTX_W'(t.ax + wd);
				t.cy = t.ay;
			end
		end
		return t;
	endfunction

	initial begin
		int screen_w[NUM_PHASES];
		int screen_h[NUM_PHASES];
		int phase_items[NUM_PHASES];
		sb = new();
		screen_w    = '{1024,    0, 8191, 1, 4095, 4096, 8191, 0, 640};
		screen_h    = '{ 768, 4096,    0, 1, 4095, 8191, 8191, 0, 480};
		phase_items = '{ 250,  100,  100, 150, 250, 200,  250, 200, 250};
		// The eighth phase takes a random screen size.
		screen_w[7] = $urandom_range(1, 4096);
		screen_h[7] = $urandom_range(1, 4096);

		arst_n             = 1'b0;
		tri_bus.valid      = 1'b0;
		tri_bus.vertex_a_x = '0;
		tri_bus.vertex_a_y = '0;
		tri_bus.vertex_b_x = '0;
		tri_bus.vertex_b_y = '0;
		tri_bus.vertex_c_x = '0;
		tri_bus.vertex_c_y = '0;
		tri_bus.tile_col   = '0;
		tri_bus.tile_row   = '0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.index      = REG_SCREEN_WIDTH;
		cfg_bus.data       = '0;
		tx_idle_on         = 1'b1;
		rx_idle_on         = 1'b1;
		long_hold_req      = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed beats on the reset screen of 640 x 480.
		// An eight pixel right triangle on whole pixels, in both windings: its
		// horizontal and vertical edges fall exactly on the samples, so the
		// top-left rule decides the border pixels.
		put_vtx(0, 0, 128, 0, 0, 128, 0, 0);
		put_vtx(0, 0, 0, 128, 128, 0, 0, 0);
		// A triangle well past the tile on every side, in both windings.
		put_vtx(-512, -512, 2048, -512, -512, 2048, 0, 0);
		put_vtx(-512, -512, -512, 2048, 2048, -512, 0, 0);
		// Vertices at the most negative and most positive coordinates.
		put_vtx(-131072, -131072, 131071, -131072, -131072, 131071, 0, 0);
		put_vtx(-131072, -131072, -131072, 131071, 131071, -131072, 0, 0);
		put_vtx(131071, 131071, -131072, 131071, 131071, -131072, 79, 59);
		put_vtx(131071, 131071, 131071, -131072, -131072, 131071, 79, 59);
		// The same large triangle on tiles just off the screen and at the far corner.
		put_vtx(131071, 131071, 131071, -131072, -131072, 131071, 80, 59);
		put_vtx(131071, 131071, 131071, -131072, -131072, 131071, 79, 60);
		put_vtx(131071, 131071, 131071, -131072, -131072, 131071, 511, 511);
		// Degenerate triangles: one point, then three points on a line.
		put_vtx(160, 160, 160, 160, 160, 160, 1, 1);
		put_vtx(0, 0, 512, 512, 1024, 1024, 0, 0);
		// Negative subpixel vertices, where the bounds still round up, towards plus infinity.
		put_vtx(-1, -1, -17, 200, 300, -33, 0, 0);
		put_vtx(-1, -1, 300, -33, -17, 200, 0, 0);
		// Fractional vertices whose bounds round up to the next pixel.
		put_vtx(15, 15, 15, 143, 143, 15, 0, 0);
		// A horizontal top edge running each way.
		put_vtx(16, 16, 112, 16, 64, 112, 0, 0);
		put_vtx(16, 16, 64, 112, 112, 16, 0, 0);
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			wr_reg(REG_SCREEN_WIDTH, CFG_W'(screen_w[p]));
			wr_reg(REG_SCREEN_HEIGHT, CFG_W'(screen_h[p]));
			cfg_bus.valid <= 1'b0;
			@(negedge clk);
			for (int i = 0; i < phase_items[p]; i++) begin
				// Idling comes and goes in stretches; the last phase runs flat out,
				// and in the fifth the sender never pauses so the long stall bites.
				if (i % 32 == 0) begin
					tx_idle_on = (p != NUM_PHASES - 1) && (p != 4) && ($urandom_range(0, 3) != 0);
					rx_idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
				end
				if (p == 4 && i == 120) long_hold_req = 1'b1;
				// Once mid-phase the sender waits until every mask has come back.
				if (p == 7 && i == 100) settle();
				put_tri(rand_tri());
				if (tx_idle_on && $urandom_range(0, 3) == 0) tx_gap();
			end
			settle();
		end

		repeat (2 * LATENCY) @(negedge clk);
		if (sb.errors == 0 && sb.pending_masks.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
